// File: hdl/ksrc_pkg.sv
package ksrc_pkg;

    localparam int unsigned LIMIT_W      = 7;
    localparam int unsigned PERIOD_W     = 8;
    localparam int unsigned CFG_INDEX_W  = 2;
    localparam int unsigned CFG_DATA_W   = 8;

    localparam logic [LIMIT_W-1:0]  HOLD_MAX              = 7'd127;
    localparam logic [LIMIT_W-1:0]  DEBOUNCE_LIMIT_RESET  = 7'd5;
    localparam logic [PERIOD_W-1:0] BLINK_PERIOD_RESET    = 8'd25;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DEBOUNCE_LIMIT = 2'd0,
        CFG_BLINK_PERIOD   = 2'd1
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_STOPPED  = 2'd1,
        MODE_REVIVING = 2'd2
    } mode_t;

    typedef struct packed {
        logic red_drive_n;
        logic green_drive_n;
        logic blue_drive_n;
    } led_drive_t;

endpackage

// File: hdl/ksrc_if.sv
interface ksrc_tick_if;
    logic valid;
    logic ready;
    logic kill_pressed;
    logic revive_pressed;

    modport source (output valid, output kill_pressed, output revive_pressed, input ready);
    modport sink   (input valid, input kill_pressed, input revive_pressed, output ready);
endinterface

interface ksrc_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] run_mode;
    logic       red_drive_n;
    logic       green_drive_n;
    logic       blue_drive_n;
    logic       force_stop;
    logic       chassis_enable;

    modport source (output valid, output run_mode, output red_drive_n,
                    output green_drive_n, output blue_drive_n, output force_stop,
                    output chassis_enable, input ready);
    modport sink   (input valid, input run_mode, input red_drive_n,
                    input green_drive_n, input blue_drive_n, input force_stop,
                    input chassis_enable, output ready);
endinterface

interface ksrc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ksrc_pkg::CFG_INDEX_W-1:0] index;
    logic [ksrc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/ksrc_led.sv
module ksrc_led
(
    input  ksrc_pkg::mode_t      mode,
    input  logic                 blink_phase,
    output ksrc_pkg::led_drive_t drive
);

    always_comb
    begin
        case (mode)
            ksrc_pkg::MODE_IDLE:
            begin
                drive.red_drive_n   = 1'b0;
                drive.green_drive_n = 1'b1;
                drive.blue_drive_n  = 1'b1;
            end
            ksrc_pkg::MODE_STOPPED:
            begin
                drive.red_drive_n   = ~blink_phase;
                drive.green_drive_n = 1'b1;
                drive.blue_drive_n  = ~blink_phase;
            end
            ksrc_pkg::MODE_REVIVING:
            begin
                drive.red_drive_n   = 1'b1;
                drive.green_drive_n = 1'b0;
                drive.blue_drive_n  = 1'b1;
            end
            default:
            begin
                // unused code: blue blinks
                drive.red_drive_n   = 1'b1;
                drive.green_drive_n = 1'b1;
                drive.blue_drive_n  = ~blink_phase;
            end
        endcase
    end

endmodule

// File: hdl/killswitch_run_state_controller_core.sv
// An accepted tick transaction's result is loaded into the output register for the next cycle.
// Throughput: one tick per cycle; the result register is reloaded in the cycle it is taken.
// The tick input stalls only while an untaken result is held.
// Reset: asynchronous, active low; run state idle, counters and blink phase zero,
// debounce limit 5, blink period 25, output register empty.
module killswitch_run_state_controller_core
(
    input  logic             clk,
    input  logic             rst_n,
    ksrc_tick_if.sink        tick,
    ksrc_result_if.source    result,
    ksrc_cfg_if.sink         cfg
);

    logic [ksrc_pkg::LIMIT_W-1:0]  debounce_limit_reg;
    logic [ksrc_pkg::PERIOD_W-1:0] blink_period_reg;

    ksrc_pkg::mode_t               mode_reg, mode_next;
    logic [ksrc_pkg::LIMIT_W-1:0]  hold_count_reg, hold_count_next;
    logic [ksrc_pkg::PERIOD_W-1:0] blink_count_reg, blink_count_next;
    logic                          blink_phase_reg, blink_phase_next;

    logic                          out_valid_reg;
    ksrc_pkg::mode_t               out_mode_reg;
    ksrc_pkg::led_drive_t          out_led_reg;
    logic                          out_force_stop_reg;
    logic                          out_enable_reg;

    logic [ksrc_pkg::PERIOD_W:0]   blink_inc;
    logic [ksrc_pkg::LIMIT_W-1:0]  hold_inc;
    logic                          enable_next;
    logic                          tick_accept;
    ksrc_pkg::led_drive_t          led_next;

    assign tick.ready  = ~out_valid_reg | result.ready;
    assign tick_accept = tick.valid & tick.ready;
    assign cfg.ready   = 1'b1;

    always_comb
    begin
        blink_inc = {1'b0, blink_count_reg} + 9'd1;
        if (blink_inc >= {1'b0, blink_period_reg})
        begin
            blink_count_next = '0;
            blink_phase_next = ~blink_phase_reg;
        end
        else
        begin
            blink_count_next = blink_inc[ksrc_pkg::PERIOD_W-1:0];
            blink_phase_next = blink_phase_reg;
        end
    end

    always_comb
    begin
        hold_inc        = (hold_count_reg < ksrc_pkg::HOLD_MAX) ? hold_count_reg + 7'd1
                                                                : hold_count_reg;
        mode_next       = mode_reg;
        enable_next     = 1'b0;
        hold_count_next = '0;
        if (tick.kill_pressed)
        begin
            hold_count_next = hold_inc;
            if (hold_inc == debounce_limit_reg)
            begin
                if (mode_reg == ksrc_pkg::MODE_STOPPED)
                begin
                    mode_next   = ksrc_pkg::MODE_IDLE;
                    enable_next = 1'b1;
                end
                else
                begin
                    mode_next = ksrc_pkg::MODE_STOPPED;
                end
            end
        end
        else if (tick.revive_pressed)
        begin
            if (mode_reg == ksrc_pkg::MODE_IDLE)
            begin
                mode_next = ksrc_pkg::MODE_REVIVING;
            end
        end
        else if (mode_reg == ksrc_pkg::MODE_REVIVING)
        begin
            mode_next   = ksrc_pkg::MODE_IDLE;
            enable_next = 1'b1;
        end
    end

    ksrc_led u_led
    (
        .mode        (mode_next),
        .blink_phase (blink_phase_next),
        .drive       (led_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_limit_reg <= ksrc_pkg::DEBOUNCE_LIMIT_RESET;
            blink_period_reg   <= ksrc_pkg::BLINK_PERIOD_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                ksrc_pkg::CFG_DEBOUNCE_LIMIT:
                    debounce_limit_reg <= cfg.data[ksrc_pkg::LIMIT_W-1:0];
                ksrc_pkg::CFG_BLINK_PERIOD:
                    blink_period_reg <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= ksrc_pkg::MODE_IDLE;
            hold_count_reg  <= '0;
            blink_count_reg <= '0;
            blink_phase_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (tick_accept)
            begin
                mode_reg        <= mode_next;
                hold_count_reg  <= hold_count_next;
                blink_count_reg <= blink_count_next;
                blink_phase_reg <= blink_phase_next;
                out_valid_reg   <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_accept)
        begin
            out_mode_reg       <= mode_next;
            out_led_reg        <= led_next;
            out_force_stop_reg <= (mode_next == ksrc_pkg::MODE_STOPPED);
            out_enable_reg     <= enable_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.run_mode       = out_mode_reg;
    assign result.red_drive_n    = out_led_reg.red_drive_n;
    assign result.green_drive_n  = out_led_reg.green_drive_n;
    assign result.blue_drive_n   = out_led_reg.blue_drive_n;
    assign result.force_stop     = out_force_stop_reg;
    assign result.chassis_enable = out_enable_reg;

endmodule
